### rtl/tsrf_pkg.sv
// Shared types and constants for the text screen rectangle engine.
// No dependencies; text_screen_rect_fill_move_core imports this package.
package tsrf_pkg;

  localparam int unsigned DefaultCols = 80;
  localparam int unsigned DefaultRows = 25;

  localparam logic [7:0] BlankChar  = 8'h20;
  localparam logic [7:0] ResetColor = 8'h07;

  localparam logic [1:0] CMD_FILL = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_MV_COPY,
    ST_MV_BLANK,
    ST_MV_PUT,
    ST_READ,
    ST_FINISH
  } tsrf_state_e;

endpackage

### rtl/tsrf_req_if.sv
// Request channel of the rectangle engine: valid/ready plus the command fields.
// No dependencies.
interface tsrf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] src_col;
  logic [7:0] src_row;
  logic [7:0] dst_col;
  logic [7:0] dst_row;
  logic [7:0] rect_width;
  logic [7:0] rect_height;
  logic [7:0] fill_char;
  logic [7:0] fill_color;

  modport source (
    output valid, command, src_col, src_row, dst_col, dst_row,
           rect_width, rect_height, fill_char, fill_color,
    input  ready
  );
  modport sink (
    input  valid, command, src_col, src_row, dst_col, dst_row,
           rect_width, rect_height, fill_char, fill_color,
    output ready
  );
endinterface

### rtl/tsrf_rsp_if.sv
// Response channel of the rectangle engine: valid/ready plus the result fields.
// No dependencies.
interface tsrf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic [7:0] cell_color;
  logic       status;

  modport source (
    output valid, cell_char, cell_color, status,
    input  ready
  );
  modport sink (
    input  valid, cell_char, cell_color, status,
    output ready
  );
endinterface

### rtl/text_screen_rect_fill_move_core.sv
// Top level of the text screen rectangle engine: screen store, move buffer and sequencer.
// Depends on tsrf_pkg, tsrf_req_if and tsrf_rsp_if.
//
//   Channel          Dir  Handshake      Contents
//   req_i            in   valid/ready    command, corners, size, fill bytes
//   rsp_o            out  valid/ready    cell_char, cell_color, status
//   default_color_*  in   write enable   blanking colour for move
//
// One request is handled at a time; a finished response waits in the output register.
// After reset a clearing pass writes zero to every screen cell, one per cycle,
// with req_i.ready low.
// Each memory port makes a single cell access per cycle.
// A stalled response holds the engine in its finish state until the response is taken.
module text_screen_rect_fill_move_core #(
  parameter int unsigned COLS = tsrf_pkg::DefaultCols,
  parameter int unsigned ROWS = tsrf_pkg::DefaultRows
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tsrf_req_if.sink          req_i,
  tsrf_rsp_if.source        rsp_o,
  input  logic              default_color_we_i,
  input  logic [7:0]        default_color_i
);
  import tsrf_pkg::*;

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int IW = $clog2(510 * COLS + 511);
  localparam logic [IW-1:0] ColsIw  = IW'(COLS);
  localparam logic [IW-1:0] CellsIw = IW'(CELLS);
  localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);
  localparam logic [8:0] Cols9 = 9'(COLS);
  localparam logic [8:0] Rows9 = 9'(ROWS);

  // Memories
  logic [15:0] scr_mem [CELLS];
  logic [15:0] buf_mem [CELLS];

  logic          scr_we, scr_re, buf_we, buf_re;
  logic [AW-1:0] scr_waddr, scr_raddr, buf_waddr, buf_raddr;
  logic [15:0]   scr_wdata, buf_wdata;
  logic [15:0]   scr_rdata_q, buf_rdata_q;

  always_ff @(posedge clk_i) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (scr_re) begin
      scr_rdata_q <= scr_mem[scr_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    if (buf_re) begin
      buf_rdata_q <= buf_mem[buf_raddr];
    end
  end

  // Control state
  tsrf_state_e   state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          cp_pend_q, cp_pend_d;
  logic          put_pend_q, put_pend_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [7:0]    default_color_q;

  // Payload registers
  logic [1:0]    cmd_q, cmd_d;
  logic [7:0]    src_col_q, src_col_d, src_row_q, src_row_d;
  logic [7:0]    dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [7:0]    w_q, w_d, h_q, h_d;
  logic [15:0]   fill_val_q, fill_val_d;
  logic [IW-1:0] src_base_q, src_base_d, dst_base_q, dst_base_d;
  logic [IW-1:0] row_base_q, row_base_d, cur_q, cur_d;
  logic [7:0]    col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] cp_k_q, cp_k_d;
  logic          cp_ok_q, cp_ok_d;
  logic [AW-1:0] put_addr_q, put_addr_d;
  logic          put_ok_q, put_ok_d;
  logic          rd_ok_q, rd_ok_d;
  logic [7:0]    fin_char_q, fin_char_d, fin_color_q, fin_color_d;
  logic          fin_status_q, fin_status_d;
  logic [7:0]    rsp_char_q, rsp_char_d, rsp_color_q, rsp_color_d;
  logic          rsp_status_q, rsp_status_d;

  logic          cur_ok, last_col, last_cell, empty, reject;
  logic [IW-1:0] src_base_calc, dst_base_calc;

  assign cur_ok    = cur_q < CellsIw;
  assign last_col  = col_cnt_q == (w_q - 8'd1);
  assign last_cell = last_col && (row_cnt_q == (h_q - 8'd1));
  assign empty     = (w_q == 8'd0) || (h_q == 8'd0);
  assign reject    = ({1'b0, src_col_q} > Cols9) || ({1'b0, dst_col_q} > Cols9) ||
                     ({1'b0, w_q} > Cols9) || ({1'b0, src_row_q} > Rows9) ||
                     ({1'b0, dst_row_q} > Rows9) || ({1'b0, h_q} > Rows9);
  assign src_base_calc = IW'(src_row_q) * ColsIw + IW'(src_col_q);
  assign dst_base_calc = IW'(dst_row_q) * ColsIw + IW'(dst_col_q);

  assign req_i.ready      = state_q == ST_IDLE;
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.cell_char  = rsp_char_q;
  assign rsp_o.cell_color = rsp_color_q;
  assign rsp_o.status     = rsp_status_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    cp_pend_d    = 1'b0;
    put_pend_d   = 1'b0;
    rsp_valid_d  = rsp_valid_q;
    cmd_d        = cmd_q;
    src_col_d    = src_col_q;
    src_row_d    = src_row_q;
    dst_col_d    = dst_col_q;
    dst_row_d    = dst_row_q;
    w_d          = w_q;
    h_d          = h_q;
    fill_val_d   = fill_val_q;
    src_base_d   = src_base_q;
    dst_base_d   = dst_base_q;
    row_base_d   = row_base_q;
    cur_d        = cur_q;
    col_cnt_d    = col_cnt_q;
    row_cnt_d    = row_cnt_q;
    k_d          = k_q;
    cp_k_d       = cp_k_q;
    cp_ok_d      = cp_ok_q;
    put_addr_d   = put_addr_q;
    put_ok_d     = put_ok_q;
    rd_ok_d      = rd_ok_q;
    fin_char_d   = fin_char_q;
    fin_color_d  = fin_color_q;
    fin_status_d = fin_status_q;
    rsp_char_d   = rsp_char_q;
    rsp_color_d  = rsp_color_q;
    rsp_status_d = rsp_status_q;

    scr_we    = 1'b0;
    scr_waddr = cur_q[AW-1:0];
    scr_wdata = fill_val_q;
    scr_re    = 1'b0;
    scr_raddr = cur_q[AW-1:0];
    buf_we    = cp_pend_q;
    buf_waddr = cp_k_q;
    buf_wdata = cp_ok_q ? scr_rdata_q : 16'h0000;
    buf_re    = 1'b0;
    buf_raddr = k_q;

    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    // Walk the rectangle: next cell in the row, or wrap to the next row.
    if (last_col) begin
      col_cnt_d  = 8'd0;
      row_cnt_d  = row_cnt_q + 8'd1;
      row_base_d = row_base_q + ColsIw;
      cur_d      = row_base_q + ColsIw;
    end else begin
      col_cnt_d = col_cnt_q + 8'd1;
      cur_d     = cur_q + IW'(1);
    end

    unique case (state_q)
      ST_CLEAR: begin
        scr_we    = 1'b1;
        scr_waddr = clr_q;
        scr_wdata = 16'h0000;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LastCell) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          cmd_d      = req_i.command;
          src_col_d  = req_i.src_col;
          src_row_d  = req_i.src_row;
          dst_col_d  = req_i.dst_col;
          dst_row_d  = req_i.dst_row;
          w_d        = req_i.rect_width;
          h_d        = req_i.rect_height;
          fill_val_d = {req_i.fill_color, req_i.fill_char};
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        fin_char_d   = 8'd0;
        fin_color_d  = 8'd0;
        fin_status_d = 1'b0;
        src_base_d   = src_base_calc;
        dst_base_d   = dst_base_calc;
        row_base_d   = src_base_calc;
        cur_d        = src_base_calc;
        col_cnt_d    = 8'd0;
        row_cnt_d    = 8'd0;
        k_d          = '0;
        state_d      = ST_FINISH;
        unique case (cmd_q)
          CMD_FILL: begin
            if (!empty) begin
              state_d = ST_FILL;
            end
          end
          CMD_MOVE: begin
            if (reject) begin
              fin_status_d = 1'b1;
            end else if (!empty) begin
              state_d = ST_MV_COPY;
            end
          end
          CMD_READ: begin
            scr_re    = src_base_calc < CellsIw;
            scr_raddr = src_base_calc[AW-1:0];
            rd_ok_d   = src_base_calc < CellsIw;
            state_d   = ST_READ;
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_FILL: begin
        scr_we = cur_ok;
        if (last_cell) begin
          state_d = ST_FINISH;
        end
      end
      ST_MV_COPY: begin
        // Source cells outside the store read as zero in the buffer.
        scr_re    = cur_ok;
        cp_pend_d = 1'b1;
        cp_k_d    = k_q;
        cp_ok_d   = cur_ok;
        k_d       = k_q + AW'(1);
        if (last_cell) begin
          row_base_d = src_base_q;
          cur_d      = src_base_q;
          col_cnt_d  = 8'd0;
          row_cnt_d  = 8'd0;
          state_d    = ST_MV_BLANK;
        end
      end
      ST_MV_BLANK: begin
        scr_we    = cur_ok;
        scr_wdata = {default_color_q, BlankChar};
        if (last_cell) begin
          row_base_d = dst_base_q;
          cur_d      = dst_base_q;
          col_cnt_d  = 8'd0;
          row_cnt_d  = 8'd0;
          k_d        = '0;
          state_d    = ST_MV_PUT;
        end
      end
      ST_MV_PUT: begin
        buf_re     = 1'b1;
        put_pend_d = 1'b1;
        put_addr_d = cur_q[AW-1:0];
        put_ok_d   = cur_ok;
        k_d        = k_q + AW'(1);
        if (last_cell) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ: begin
        fin_char_d  = rd_ok_q ? scr_rdata_q[7:0] : 8'd0;
        fin_color_d = rd_ok_q ? scr_rdata_q[15:8] : 8'd0;
        state_d     = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_char_d   = fin_char_q;
          rsp_color_d  = fin_color_q;
          rsp_status_d = fin_status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // The destination write of a move lands in the cycle after its buffer read.
    if (put_pend_q && put_ok_q) begin
      scr_we    = 1'b1;
      scr_waddr = put_addr_q;
      scr_wdata = buf_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_q           <= '0;
      cp_pend_q       <= 1'b0;
      put_pend_q      <= 1'b0;
      rsp_valid_q     <= 1'b0;
      default_color_q <= ResetColor;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cp_pend_q   <= cp_pend_d;
      put_pend_q  <= put_pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (default_color_we_i) begin
        default_color_q <= default_color_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    src_col_q    <= src_col_d;
    src_row_q    <= src_row_d;
    dst_col_q    <= dst_col_d;
    dst_row_q    <= dst_row_d;
    w_q          <= w_d;
    h_q          <= h_d;
    fill_val_q   <= fill_val_d;
    src_base_q   <= src_base_d;
    dst_base_q   <= dst_base_d;
    row_base_q   <= row_base_d;
    cur_q        <= cur_d;
    col_cnt_q    <= col_cnt_d;
    row_cnt_q    <= row_cnt_d;
    k_q          <= k_d;
    cp_k_q       <= cp_k_d;
    cp_ok_q      <= cp_ok_d;
    put_addr_q   <= put_addr_d;
    put_ok_q     <= put_ok_d;
    rd_ok_q      <= rd_ok_d;
    fin_char_q   <= fin_char_d;
    fin_color_q  <= fin_color_d;
    fin_status_q <= fin_status_d;
    rsp_char_q   <= rsp_char_d;
    rsp_color_q  <= rsp_color_d;
    rsp_status_q <= rsp_status_d;
  end

`ifndef SYNTHESIS
  a_scr_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scr_we |-> scr_waddr <= LastCell)
    else $error("screen write beyond the store");

  a_reject_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status) |-> (rsp_o.cell_char == 8'd0 && rsp_o.cell_color == 8'd0))
    else $error("rejected move returned cell bytes");

  a_copy_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_pend_q |-> (state_q == ST_MV_COPY || state_q == ST_MV_BLANK))
    else $error("buffer write pending outside the move copy");

  a_put_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    put_pend_q |-> (state_q == ST_MV_PUT || state_q == ST_FINISH))
    else $error("destination write pending after the move ended");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !scr_we)
    else $error("screen written while idle");
`endif

endmodule
